/* rtl/hab_pkg.sv */
// Package: shared types, constants and helper functions of the hex accumulator machine.
`timescale 1ns / 1ps
`default_nettype none
package hab_pkg;

   localparam int MEM_DEPTH_DEF = 8192;
   localparam int NUM_REGS      = 6;

   // configuration reset values
   localparam logic [12:0] START_RST = 13'd256;
   localparam logic [12:0] DBASE_RST = 13'd5;
   localparam logic [12:0] RBASE_RST = 13'd100;

   // request codes
   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_EXEC    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_START = 2'd0;
   localparam logic [1:0] CSR_DBASE = 2'd1;
   localparam logic [1:0] CSR_RBASE = 2'd2;

   // machine status and error codes
   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_HALT = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_OPCODE = 2'd1;
   localparam logic [1:0] ERR_ADDR   = 2'd2;

   // characters the machine looks at
   localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
   localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]
   localparam logic [7:0] CH_LREG  = 8'h69;  // i
   localparam logic [7:0] CH_UREG  = 8'h49;  // I

   typedef enum logic [4:0] {
      C_HALT, C_HEX, C_RSTORE, C_RLOAD, C_JMPACC, C_GETPC,
      C_PUSHD, C_PUSHR, C_POPD, C_POPR, C_DROP, C_EMIT,
      C_ADD, C_SUB, C_AND, C_OR, C_XOR, C_STORE, C_LOAD,
      C_NOT, C_CLR, C_SHL, C_SAR, C_FWD, C_BKNZ, C_BKZ, C_NOP, C_BAD
   } opclass_type;

   typedef enum logic [2:0] {
      ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_NOT16, ALU_SHL, ALU_SAR
   } alu_op_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FETCH, S_POP, S_OPND, S_LOAD,
      S_OFFS, S_JCHK, S_SCAN, S_WB, S_RESP
   } state_type;

   // opcode byte to instruction class
   function automatic opclass_type classify(logic [7:0] b);
      opclass_type c;
      unique case (b) inside
         8'h48:                       c = C_HALT;
         [8'h30:8'h39], [8'h61:8'h66]: c = C_HEX;
         [8'h69:8'h6E]:               c = C_RSTORE;
         [8'h49:8'h4E]:               c = C_RLOAD;
         8'h70:                       c = C_JMPACC;
         8'h50:                       c = C_GETPC;
         8'h73:                       c = C_PUSHD;
         8'h72:                       c = C_PUSHR;
         8'h53:                       c = C_POPD;
         8'h52:                       c = C_POPR;
         8'h44:                       c = C_DROP;
         8'h2E:                       c = C_EMIT;
         8'h2B:                       c = C_ADD;
         8'h2D:                       c = C_SUB;
         8'h41:                       c = C_AND;
         8'h4F:                       c = C_OR;
         8'h58:                       c = C_XOR;
         8'h21:                       c = C_STORE;
         8'h40:                       c = C_LOAD;
         8'h7E:                       c = C_NOT;
         8'h5F:                       c = C_CLR;
         8'h3C:                       c = C_SHL;
         8'h3E:                       c = C_SAR;
         8'h5B, 8'h5A:                c = C_FWD;
         8'h5D:                       c = C_BKNZ;
         8'h43:                       c = C_BKZ;
         8'h42, 8'h20, 8'h09, 8'h0A:  c = C_NOP;
         default:                     c = C_BAD;
      endcase
      return c;
   endfunction

   // shift one digit into a value, odd bytes included
   function automatic logic [31:0] nibble_in(logic [7:0] b, logic [31:0] val);
      logic [7:0]  d;
      logic [31:0] c;
      d = b - 8'h30;
      if (!b[7] && (b >= 8'h61)) c = {24'h0, b - 8'h57};
      else c = {{24{d[7]}}, d};
      return {16'h0, val[11:0], 4'h0} | c;
   endfunction

   // k-th written character of an offset: lowercase hex, at least 4 digits
   function automatic logic [7:0] hex_char(logic [31:0] v, logic [1:0] k);
      logic [3:0]  w;
      logic [2:0]  idx;
      logic [31:0] sh;
      logic [3:0]  nb;
      w = 4'd4;
      for (int i = 4; i < 8; i++) begin
         if (v[4*i +: 4] != 4'h0) w = 4'(i + 1);
      end
      idx = 3'(w - 4'd1 - {2'b00, k});
      sh  = v >> {idx, 2'b00};
      nb  = sh[3:0];
      return (nb < 4'd10) ? (8'h30 + {4'h0, nb}) : (8'h57 + {4'h0, nb});
   endfunction

   // stack slot address, pointer read as signed
   function automatic logic [17:0] stk_addr(logic [12:0] base, logic [15:0] sp);
      return {5'b0, base} + {{2{sp[15]}}, sp};
   endfunction

endpackage
`default_nettype wire

/* rtl/hab_if.sv */
// Interfaces: request and response channels of the hex accumulator machine.
`timescale 1ns / 1ps
`default_nettype none
interface hab_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [12:0] load_address;
   logic [7:0]  program_byte;
   modport source (output valid, op, load_address, program_byte, input ready);
   modport sink (input valid, op, load_address, program_byte, output ready);
endinterface

interface hab_rsp_if;
   logic               valid;
   logic               ready;
   logic               char_valid;
   logic [7:0]         out_char;
   logic [1:0]         machine_status;
   logic [1:0]         error_code;
   logic signed [31:0] accumulator_value;
   logic signed [31:0] counter_value;
   modport source (output valid, char_valid, out_char, machine_status, error_code,
                   accumulator_value, counter_value, input ready);
   modport sink (input valid, char_valid, out_char, machine_status, error_code,
                 accumulator_value, counter_value, output ready);
endinterface
`default_nettype wire

/* rtl/hab_mem.sv */
// Byte memory: single port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hab_mem #(
   parameter int DEPTH = hab_pkg::MEM_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic          we,
   input  wire logic [AW-1:0] addr,
   input  wire logic [7:0]    wdata,
   output logic [7:0]         rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   // one access per cycle: write or read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) mem[addr] <= wdata;
         else rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* rtl/hab_alu.sv */
// Shared arithmetic unit: accumulator operations and jump targets.
`timescale 1ns / 1ps
`default_nettype none
module hab_alu (
   input  wire hab_pkg::alu_op_type op,
   input  wire logic [31:0]         a,
   input  wire logic [31:0]         b,
   output logic [31:0]              y
);

   always_comb begin
      unique case (op)
         hab_pkg::ALU_ADD:   y = a + b;
         hab_pkg::ALU_SUB:   y = a - b;
         hab_pkg::ALU_AND:   y = a & b;
         hab_pkg::ALU_OR:    y = a | b;
         hab_pkg::ALU_XOR:   y = a ^ b;
         hab_pkg::ALU_NOT16: y = {16'h0, ~a[15:0]};
         hab_pkg::ALU_SHL:   y = {a[30:0], 1'b0};
         hab_pkg::ALU_SAR:   y = {a[31], a[31:1]};
         default:            y = a;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/hex_accumulator_bytecode_machine_unit.sv */
// Top level: sequencer of the hex accumulator machine around one byte memory and one ALU.
// A bracket scan walks memory one byte at a time and then writes the found offset back.
// Throughput: one item at a time, set by the single memory port and the sequencer.
// Reset (synchronous): clears all machine state, then sweeps memory to zero with ready
// low; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module hex_accumulator_bytecode_machine_unit #(
   parameter int MEM_DEPTH = hab_pkg::MEM_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hab_req_if.sink          req_bus,
   hab_rsp_if.source        rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);

   localparam int          AW       = $clog2(MEM_DEPTH);
   localparam logic [31:0] MEM_LIM  = 32'(MEM_DEPTH);
   localparam logic [17:0] STK_LIM  = 18'(MEM_DEPTH);
   localparam logic [AW:0] SCAN_LIM = (AW+1)'(MEM_DEPTH);
   localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

   hab_pkg::state_type   state_ff, state_in;
   hab_pkg::opclass_type cls_ff, cls_in, cls_now;

   logic [31:0] acc_ff, acc_in, pc_ff, pc_in;
   logic [31:0] regs_ff [hab_pkg::NUM_REGS];
   logic [31:0] regs_in [hab_pkg::NUM_REGS];
   logic [15:0] dstk_ff, dstk_in, rstk_ff, rstk_in;
   logic [1:0]  status_ff, status_in, err_ff, err_in;
   logic [12:0] start_ff, dbase_ff, rbase_ff;
   logic [31:0] dest_ff, dest_in, n_ff, n_in;
   logic [17:0] depth_ff, depth_in;
   logic [1:0]  k_ff, k_in;
   logic [AW-1:0] saddr_ff, saddr_in, clr_ff, clr_in;
   logic        emit_ff, emit_in;
   logic [7:0]  char_ff, char_in;

   logic          mem_en, mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata, mem_rdata;

   hab_pkg::alu_op_type alu_op;
   logic [31:0] alu_a, alu_b, alu_y;

   logic [31:0] pc_inc;
   logic [17:0] dpush_a, dpop_a, rpush_a, rpop_a;
   logic [15:0] dstk_dec, rstk_dec;
   logic        dpush_ok, dpop_ok, rpush_ok, rpop_ok;
   logic [2:0]  ridx_st, ridx_ld;
   logic        fwd, jcond;
   logic [AW:0] scan_next;

   hab_mem #(.DEPTH(MEM_DEPTH), .AW(AW)) u_mem (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   hab_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   // address helpers
   assign pc_inc   = pc_ff + 32'd1;
   assign dstk_dec = dstk_ff - 16'd1;
   assign rstk_dec = rstk_ff - 16'd1;
   assign dpush_a  = hab_pkg::stk_addr(dbase_ff, dstk_ff);
   assign dpop_a   = hab_pkg::stk_addr(dbase_ff, dstk_dec);
   assign rpush_a  = hab_pkg::stk_addr(rbase_ff, rstk_ff);
   assign rpop_a   = hab_pkg::stk_addr(rbase_ff, rstk_dec);
   assign dpush_ok = !dpush_a[17] && (dpush_a < STK_LIM);
   assign dpop_ok  = !dpop_a[17] && (dpop_a < STK_LIM);
   assign rpush_ok = !rpush_a[17] && (rpush_a < STK_LIM);
   assign rpop_ok  = !rpop_a[17] && (rpop_a < STK_LIM);
   assign cls_now  = hab_pkg::classify(mem_rdata);
   assign ridx_st  = 3'(mem_rdata - hab_pkg::CH_LREG);
   assign ridx_ld  = 3'(mem_rdata - hab_pkg::CH_UREG);
   assign fwd      = (cls_ff == hab_pkg::C_FWD);
   assign scan_next = fwd ? ({1'b0, saddr_ff} + (AW+1)'(1))
                          : ({1'b0, saddr_ff} - (AW+1)'(1));

   // jump condition of the fetched bracket opcode
   always_comb begin
      unique case (cls_now)
         hab_pkg::C_BKNZ: jcond = (acc_ff != 32'd0);
         default:         jcond = (acc_ff == 32'd0);
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= hab_pkg::START_RST;
         dbase_ff <= hab_pkg::DBASE_RST;
         rbase_ff <= hab_pkg::RBASE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            hab_pkg::CSR_START: start_ff <= csr_wdata;
            hab_pkg::CSR_DBASE: dbase_ff <= csr_wdata;
            hab_pkg::CSR_RBASE: rbase_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state register and machine state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hab_pkg::S_CLEAR;
         acc_ff    <= 32'd0;
         pc_ff     <= {19'd0, hab_pkg::START_RST};
         for (int i = 0; i < hab_pkg::NUM_REGS; i++) regs_ff[i] <= 32'd0;
         dstk_ff   <= 16'd0;
         rstk_ff   <= 16'd0;
         status_ff <= hab_pkg::ST_RUN;
         err_ff    <= hab_pkg::ERR_NONE;
         emit_ff   <= 1'b0;
         clr_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         acc_ff    <= acc_in;
         pc_ff     <= pc_in;
         regs_ff   <= regs_in;
         dstk_ff   <= dstk_in;
         rstk_ff   <= rstk_in;
         status_ff <= status_in;
         err_ff    <= err_in;
         emit_ff   <= emit_in;
         clr_ff    <= clr_in;
      end
   end

   // working registers of the sequencer
   always_ff @(posedge clock) begin
      cls_ff   <= cls_in;
      dest_ff  <= dest_in;
      n_ff     <= n_in;
      depth_ff <= depth_in;
      k_ff     <= k_in;
      saddr_ff <= saddr_in;
      char_ff  <= char_in;
   end

   // sequencer: next state, memory port and ALU control
   always_comb begin
      state_in  = state_ff;
      cls_in    = cls_ff;
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      regs_in   = regs_ff;
      dstk_in   = dstk_ff;
      rstk_in   = rstk_ff;
      status_in = status_ff;
      err_in    = err_ff;
      dest_in   = dest_ff;
      n_in      = n_ff;
      depth_in  = depth_ff;
      k_in      = k_ff;
      saddr_in  = saddr_ff;
      clr_in    = clr_ff;
      emit_in   = emit_ff;
      char_in   = char_ff;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = pc_ff[AW-1:0];
      mem_wdata = acc_ff[7:0];
      alu_op    = hab_pkg::ALU_ADD;
      alu_a     = acc_ff;
      alu_b     = {{24{mem_rdata[7]}}, mem_rdata};

      unique case (state_ff)
         // zero the memory after reset
         hab_pkg::S_CLEAR: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = 8'h00;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) state_in = hab_pkg::S_IDLE;
         end

         hab_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               emit_in  = 1'b0;
               char_in  = 8'h00;
               state_in = hab_pkg::S_RESP;
               unique case (req_bus.op)
                  hab_pkg::REQ_WRITE: begin
                     if ({19'd0, req_bus.load_address} < MEM_LIM) begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = AW'(req_bus.load_address);
                        mem_wdata = req_bus.program_byte;
                     end
                  end
                  hab_pkg::REQ_EXEC: begin
                     if (status_ff == hab_pkg::ST_RUN) begin
                        if (pc_ff < MEM_LIM) begin
                           mem_en   = 1'b1;
                           state_in = hab_pkg::S_FETCH;
                        end else begin
                           status_in = hab_pkg::ST_ERR;
                           err_in    = hab_pkg::ERR_ADDR;
                        end
                     end
                  end
                  hab_pkg::REQ_RESTART: begin
                     for (int i = 0; i < hab_pkg::NUM_REGS; i++) regs_in[i] = 32'd0;
                     acc_in    = 32'd0;
                     pc_in     = {19'd0, start_ff};
                     dstk_in   = 16'd0;
                     rstk_in   = 16'd0;
                     status_in = hab_pkg::ST_RUN;
                     err_in    = hab_pkg::ERR_NONE;
                  end
                  default: ;
               endcase
            end
         end

         // decode the fetched opcode
         hab_pkg::S_FETCH: begin
            cls_in   = cls_now;
            state_in = hab_pkg::S_RESP;
            pc_in    = pc_inc;
            unique case (cls_now)
               hab_pkg::C_HALT: begin
                  pc_in     = pc_ff;
                  status_in = hab_pkg::ST_HALT;
               end
               hab_pkg::C_HEX:    acc_in = hab_pkg::nibble_in(mem_rdata, acc_ff);
               hab_pkg::C_RSTORE: regs_in[ridx_st] = acc_ff;
               hab_pkg::C_RLOAD:  acc_in = regs_ff[ridx_ld];
               hab_pkg::C_JMPACC: pc_in = acc_ff;
               hab_pkg::C_GETPC:  acc_in = pc_ff;
               hab_pkg::C_PUSHD, hab_pkg::C_PUSHR: begin
                  if ((cls_now == hab_pkg::C_PUSHD) ? dpush_ok : rpush_ok) begin
                     mem_en = 1'b1;
                     mem_we = 1'b1;
                     if (cls_now == hab_pkg::C_PUSHD) begin
                        mem_addr = AW'(dpush_a);
                        dstk_in  = dstk_ff + 16'd1;
                     end else begin
                        mem_addr = AW'(rpush_a);
                        rstk_in  = rstk_ff + 16'd1;
                     end
                  end else begin
                     pc_in     = pc_ff;
                     status_in = hab_pkg::ST_ERR;
                     err_in    = hab_pkg::ERR_ADDR;
                  end
               end
               hab_pkg::C_POPR: begin
                  pc_in = pc_ff;
                  if (rpop_ok) begin
                     mem_en   = 1'b1;
                     mem_addr = AW'(rpop_a);
                     state_in = hab_pkg::S_POP;
                  end else begin
                     status_in = hab_pkg::ST_ERR;
                     err_in    = hab_pkg::ERR_ADDR;
                  end
               end
               hab_pkg::C_POPD, hab_pkg::C_ADD, hab_pkg::C_SUB, hab_pkg::C_AND,
               hab_pkg::C_OR, hab_pkg::C_XOR, hab_pkg::C_STORE, hab_pkg::C_LOAD: begin
                  pc_in = pc_ff;
                  if (dpop_ok) begin
                     mem_en   = 1'b1;
                     mem_addr = AW'(dpop_a);
                     state_in = (cls_now == hab_pkg::C_POPD) ? hab_pkg::S_POP
                                                             : hab_pkg::S_OPND;
                  end else begin
                     status_in = hab_pkg::ST_ERR;
                     err_in    = hab_pkg::ERR_ADDR;
                  end
               end
               hab_pkg::C_DROP: dstk_in = dstk_dec;
               hab_pkg::C_EMIT: begin
                  emit_in = 1'b1;
                  char_in = acc_ff[7:0];
               end
               hab_pkg::C_NOT: begin
                  alu_op = hab_pkg::ALU_NOT16;
                  acc_in = alu_y;
               end
               hab_pkg::C_CLR: acc_in = 32'd0;
               hab_pkg::C_SHL: begin
                  alu_op = hab_pkg::ALU_SHL;
                  acc_in = alu_y;
               end
               hab_pkg::C_SAR: begin
                  alu_op = hab_pkg::ALU_SAR;
                  acc_in = alu_y;
               end
               hab_pkg::C_FWD, hab_pkg::C_BKNZ, hab_pkg::C_BKZ: begin
                  if (!jcond) begin
                     alu_a = pc_ff;
                     alu_b = 32'd5;
                     pc_in = alu_y;
                  end else begin
                     pc_in = pc_ff;
                     if ((pc_ff + 32'd4) < MEM_LIM) begin
                        mem_en   = 1'b1;
                        mem_addr = pc_ff[AW-1:0] + AW'(1);
                        saddr_in = pc_ff[AW-1:0] + AW'(1);
                        dest_in  = 32'd0;
                        k_in     = 2'd0;
                        state_in = hab_pkg::S_OFFS;
                     end else begin
                        status_in = hab_pkg::ST_ERR;
                        err_in    = hab_pkg::ERR_ADDR;
                     end
                  end
               end
               hab_pkg::C_NOP: ;
               default: begin
                  pc_in     = pc_ff;
                  status_in = hab_pkg::ST_ERR;
                  err_in    = hab_pkg::ERR_OPCODE;
               end
            endcase
         end

         // stack pop: sign-extend the byte
         hab_pkg::S_POP: begin
            acc_in = {{24{mem_rdata[7]}}, mem_rdata};
            if (cls_ff == hab_pkg::C_POPD) dstk_in = dstk_dec;
            else rstk_in = rstk_dec;
            pc_in    = pc_inc;
            state_in = hab_pkg::S_RESP;
         end

         // operand from top of data stack
         hab_pkg::S_OPND: begin
            state_in = hab_pkg::S_RESP;
            pc_in    = pc_inc;
            unique case (cls_ff)
               hab_pkg::C_ADD: begin alu_op = hab_pkg::ALU_ADD; acc_in = alu_y; end
               hab_pkg::C_SUB: begin alu_op = hab_pkg::ALU_SUB; acc_in = alu_y; end
               hab_pkg::C_AND: begin alu_op = hab_pkg::ALU_AND; acc_in = alu_y; end
               hab_pkg::C_OR:  begin alu_op = hab_pkg::ALU_OR;  acc_in = alu_y; end
               hab_pkg::C_XOR: begin alu_op = hab_pkg::ALU_XOR; acc_in = alu_y; end
               default: begin
                  // indirect store or load through the signed top byte
                  if (mem_rdata[7]) begin
                     pc_in     = pc_ff;
                     status_in = hab_pkg::ST_ERR;
                     err_in    = hab_pkg::ERR_ADDR;
                  end else begin
                     mem_en   = 1'b1;
                     mem_addr = AW'(mem_rdata);
                     if (cls_ff == hab_pkg::C_STORE) begin
                        mem_we = 1'b1;
                     end else begin
                        pc_in    = pc_ff;
                        state_in = hab_pkg::S_LOAD;
                     end
                  end
               end
            endcase
         end

         hab_pkg::S_LOAD: begin
            acc_in   = {{24{mem_rdata[7]}}, mem_rdata};
            pc_in    = pc_inc;
            state_in = hab_pkg::S_RESP;
         end

         // gather the four offset digits
         hab_pkg::S_OFFS: begin
            dest_in = hab_pkg::nibble_in(mem_rdata, dest_ff);
            if (k_ff == 2'd3) begin
               state_in = hab_pkg::S_JCHK;
            end else begin
               k_in     = k_ff + 2'd1;
               mem_en   = 1'b1;
               mem_addr = saddr_ff + AW'(1);
               saddr_in = saddr_ff + AW'(1);
            end
         end

         // stored offset taken, or start the bracket scan
         hab_pkg::S_JCHK: begin
            alu_a    = pc_ff;
            alu_b    = dest_ff;
            alu_op   = fwd ? hab_pkg::ALU_ADD : hab_pkg::ALU_SUB;
            depth_in = 18'd0;
            k_in     = 2'd0;
            if (dest_ff != 32'd0) begin
               pc_in    = alu_y;
               state_in = hab_pkg::S_RESP;
            end else if (fwd) begin
               if ((pc_ff + 32'd5) < MEM_LIM) begin
                  mem_en   = 1'b1;
                  mem_addr = pc_ff[AW-1:0] + AW'(5);
                  saddr_in = pc_ff[AW-1:0] + AW'(5);
                  n_in     = 32'd5;
                  state_in = hab_pkg::S_SCAN;
               end else begin
                  status_in = hab_pkg::ST_ERR;
                  err_in    = hab_pkg::ERR_ADDR;
                  state_in  = hab_pkg::S_RESP;
               end
            end else begin
               if (pc_ff != 32'd0) begin
                  mem_en   = 1'b1;
                  mem_addr = pc_ff[AW-1:0] - AW'(1);
                  saddr_in = pc_ff[AW-1:0] - AW'(1);
                  n_in     = 32'd1;
                  state_in = hab_pkg::S_SCAN;
               end else begin
                  status_in = hab_pkg::ST_ERR;
                  err_in    = hab_pkg::ERR_ADDR;
                  state_in  = hab_pkg::S_RESP;
               end
            end
         end

         // walk to the matching bracket, one byte a cycle
         hab_pkg::S_SCAN: begin
            if (mem_rdata == (fwd ? hab_pkg::CH_CLOSE : hab_pkg::CH_OPEN)
                && depth_ff == 18'd0) begin
               dest_in  = fwd ? (n_ff + 32'd5) : (n_ff - 32'd5);
               state_in = hab_pkg::S_WB;
            end else begin
               if (mem_rdata == (fwd ? hab_pkg::CH_CLOSE : hab_pkg::CH_OPEN))
                  depth_in = depth_ff - 18'd1;
               else if (mem_rdata == (fwd ? hab_pkg::CH_OPEN : hab_pkg::CH_CLOSE))
                  depth_in = depth_ff + 18'd1;
               n_in = n_ff + 32'd1;
               if (fwd ? (scan_next < SCAN_LIM) : (saddr_ff != '0)) begin
                  mem_en   = 1'b1;
                  mem_addr = scan_next[AW-1:0];
                  saddr_in = scan_next[AW-1:0];
               end else begin
                  status_in = hab_pkg::ST_ERR;
                  err_in    = hab_pkg::ERR_ADDR;
                  state_in  = hab_pkg::S_RESP;
               end
            end
         end

         // write the found offset back as four hex characters
         hab_pkg::S_WB: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = pc_ff[AW-1:0] + AW'(k_ff) + AW'(1);
            mem_wdata = hab_pkg::hex_char(dest_ff, k_ff);
            alu_a     = pc_ff;
            alu_b     = dest_ff;
            alu_op    = fwd ? hab_pkg::ALU_ADD : hab_pkg::ALU_SUB;
            if (k_ff == 2'd3) begin
               pc_in    = alu_y;
               state_in = hab_pkg::S_RESP;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end

         hab_pkg::S_RESP: begin
            if (rsp_bus.ready) state_in = hab_pkg::S_IDLE;
         end

         default: state_in = hab_pkg::S_IDLE;
      endcase
   end

   // channel outputs
   assign req_bus.ready             = (state_ff == hab_pkg::S_IDLE);
   assign rsp_bus.valid             = (state_ff == hab_pkg::S_RESP);
   assign rsp_bus.char_valid        = emit_ff;
   assign rsp_bus.out_char          = char_ff;
   assign rsp_bus.machine_status    = status_ff;
   assign rsp_bus.error_code        = err_ff;
   assign rsp_bus.accumulator_value = $signed(acc_ff);
   assign rsp_bus.counter_value     = $signed(pc_ff);

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench: predicts and checks every response of the hex accumulator machine.
`timescale 1ns / 1ps
module tb_top;

   localparam int DEPTH       = hab_pkg::MEM_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 30000000;
   localparam int RAND_ITEMS  = 640;
   localparam logic [1:0] REQ_BAD = 2'd3;

   typedef struct packed {
      logic        char_valid;
      logic [7:0]  out_char;
      logic [1:0]  machine_status;
      logic [1:0]  error_code;
      logic [31:0] accumulator_value;
      logic [31:0] counter_value;
   } machine_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = hab_pkg::CSR_START;
   logic [12:0] csr_wdata = '0;

   hab_req_if req_bus ();
   hab_rsp_if rsp_bus ();

   hex_accumulator_bytecode_machine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // machine state as predicted
   logic [7:0]  pm_mem [DEPTH];
   logic [31:0] pm_acc, pm_pc;
   logic [31:0] pm_regs [hab_pkg::NUM_REGS];
   logic [15:0] pm_dsp, pm_rsp;
   logic [1:0]  pm_status, pm_err;
   logic [12:0] pm_start = hab_pkg::START_RST;
   logic [12:0] pm_dbase = hab_pkg::DBASE_RST;
   logic [12:0] pm_rbase = hab_pkg::RBASE_RST;

   machine_view_type expected_views[$];
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int chars_seen = 0;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   function automatic int sx8(int b);
      b = b & 255;
      return (b >= 128) ? b - 256 : b;
   endfunction

   function automatic bit in_mem(longint a);
      return a >= 0 && a < DEPTH;
   endfunction

   function automatic logic [31:0] digit_in(int num, logic [31:0] val);
      int c;
      c = (num >= 97) ? num - 97 + 10 : sx8(num - 48);
      return ((val << 4) & 32'hffff) | 32'(c);
   endfunction

   function automatic void stop_on(logic [1:0] code);
      pm_status = hab_pkg::ST_ERR;
      pm_err    = code;
   endfunction

   // offset rewritten as lowercase hex, first four characters only
   function automatic void write_offset(logic [31:0] at, logic [31:0] v);
      int d;
      logic [3:0] nb;
      d = 8;
      while (d > 4 && v[4*(d-1) +: 4] == 4'h0) d--;
      for (int k = 0; k < 4; k++) begin
         nb = v[4*(d-1-k) +: 4];
         pm_mem[at + 1 + k] = (nb < 10) ? 8'h30 + nb : 8'h57 + nb;
      end
   endfunction

   function automatic logic [31:0] read_offset(logic [31:0] pc, output bit ok);
      logic [31:0] dest;
      dest = 0;
      ok   = 1'b1;
      for (int k = 1; k < 5; k++) begin
         if (!in_mem(longint'(pc) + k)) begin
            ok = 1'b0;
            return 0;
         end
         dest = digit_in(sx8(pm_mem[pc + k]), dest);
      end
      return dest;
   endfunction

   function automatic bit jump_forward(bit cond, logic [31:0] pc);
      logic [31:0] dest;
      bit ok;
      int depth_cnt, n;
      if (!cond) begin
         pm_pc = pc + 5;
         return 1;
      end
      dest = read_offset(pc, ok);
      if (!ok) begin
         stop_on(hab_pkg::ERR_ADDR);
         return 0;
      end
      if (dest != 0) begin
         pm_pc = pc + dest;
         return 1;
      end
      depth_cnt = 0;
      n = 5;
      forever begin
         if (!in_mem(longint'(pc) + n)) begin
            stop_on(hab_pkg::ERR_ADDR);
            return 0;
         end
         if (pm_mem[pc + n] == hab_pkg::CH_CLOSE && depth_cnt == 0) break;
         if (pm_mem[pc + n] == hab_pkg::CH_CLOSE) depth_cnt--;
         else if (pm_mem[pc + n] == hab_pkg::CH_OPEN) depth_cnt++;
         n++;
      end
      dest = 32'(n + 5);
      write_offset(pc, dest);
      pm_pc = pc + dest;
      return 1;
   endfunction

   function automatic bit jump_backward(bit cond, logic [31:0] pc);
      logic [31:0] dest;
      bit ok;
      int depth_cnt, n;
      if (!cond) begin
         pm_pc = pc + 5;
         return 1;
      end
      dest = read_offset(pc, ok);
      if (!ok) begin
         stop_on(hab_pkg::ERR_ADDR);
         return 0;
      end
      if (dest != 0) begin
         pm_pc = pc - dest;
         return 1;
      end
      depth_cnt = 0;
      n = 1;
      forever begin
         if (!in_mem(longint'(pc) - n)) begin
            stop_on(hab_pkg::ERR_ADDR);
            return 0;
         end
         if (pm_mem[pc - n] == hab_pkg::CH_OPEN && depth_cnt == 0) break;
         if (pm_mem[pc - n] == hab_pkg::CH_OPEN) depth_cnt--;
         else if (pm_mem[pc - n] == hab_pkg::CH_CLOSE) depth_cnt++;
         n++;
      end
      dest = 32'(n - 5);
      write_offset(pc, dest);
      pm_pc = pc - dest;
      return 1;
   endfunction

   // one instruction at the program counter; returns 1 on emit
   function automatic bit run_instruction(output logic [7:0] ch);
      logic [31:0] pc, t;
      logic [7:0]  bc;
      logic [15:0] sp;
      longint      a, b;
      bit          advance, emitted, dstk;
      pc = pm_pc;
      advance = 1;
      emitted = 0;
      ch = 0;
      if (pc >= DEPTH) begin
         stop_on(hab_pkg::ERR_ADDR);
         return 0;
      end
      bc = pm_mem[pc];
      if (bc == "H") begin
         pm_status = hab_pkg::ST_HALT;
         return 0;
      end
      if ((bc >= "0" && bc <= "9") || (bc >= "a" && bc <= "f")) begin
         pm_acc = digit_in(bc, pm_acc);
      end else if (bc >= "i" && bc <= "n") begin
         pm_regs[bc - hab_pkg::CH_LREG] = pm_acc;
      end else if (bc >= "I" && bc <= "N") begin
         pm_acc = pm_regs[bc - hab_pkg::CH_UREG];
      end else begin
         case (bc)
            "p": begin
               pm_pc = pm_acc;
               advance = 0;
            end
            "P": pm_acc = pc;
            "s", "r": begin
               dstk = (bc == "s");
               sp = dstk ? pm_dsp : pm_rsp;
               a = longint'(dstk ? pm_dbase : pm_rbase) + longint'($signed(sp));
               if (!in_mem(a)) begin
                  stop_on(hab_pkg::ERR_ADDR);
                  return 0;
               end
               pm_mem[a] = pm_acc[7:0];
               if (dstk) pm_dsp = sp + 1;
               else pm_rsp = sp + 1;
            end
            "S", "R": begin
               dstk = (bc == "S");
               sp = (dstk ? pm_dsp : pm_rsp) - 16'd1;
               a = longint'(dstk ? pm_dbase : pm_rbase) + longint'($signed(sp));
               if (!in_mem(a)) begin
                  stop_on(hab_pkg::ERR_ADDR);
                  return 0;
               end
               pm_acc = 32'(sx8(pm_mem[a]));
               if (dstk) pm_dsp = sp;
               else pm_rsp = sp;
            end
            "D": pm_dsp = pm_dsp - 16'd1;
            ".": begin
               ch = pm_acc[7:0];
               emitted = 1;
            end
            "+", "-", "A", "O", "X", "!", "@": begin
               sp = pm_dsp - 16'd1;
               a = longint'(pm_dbase) + longint'($signed(sp));
               if (!in_mem(a)) begin
                  stop_on(hab_pkg::ERR_ADDR);
                  return 0;
               end
               t = 32'(sx8(pm_mem[a]));
               case (bc)
                  "+": pm_acc = pm_acc + t;
                  "-": pm_acc = pm_acc - t;
                  "A": pm_acc = pm_acc & t;
                  "O": pm_acc = pm_acc | t;
                  "X": pm_acc = pm_acc ^ t;
                  default: begin
                     b = sx8(pm_mem[a]);
                     if (!in_mem(b)) begin
                        stop_on(hab_pkg::ERR_ADDR);
                        return 0;
                     end
                     if (bc == "!") pm_mem[b] = pm_acc[7:0];
                     else pm_acc = 32'(sx8(pm_mem[b]));
                  end
               endcase
            end
            "~": pm_acc = ~pm_acc & 32'hffff;
            "_": pm_acc = 0;
            "<": pm_acc = pm_acc << 1;
            ">": pm_acc = (pm_acc >> 1) | (pm_acc & 32'h80000000);
            "[", "Z": begin
               if (!jump_forward(pm_acc == 0, pc)) return 0;
               advance = 0;
            end
            "]": begin
               if (!jump_backward(pm_acc != 0, pc)) return 0;
               advance = 0;
            end
            "C": begin
               if (!jump_backward(pm_acc == 0, pc)) return 0;
               advance = 0;
            end
            "B", " ", 8'h09, 8'h0A: ;
            default: begin
               stop_on(hab_pkg::ERR_OPCODE);
               return 0;
            end
         endcase
      end
      if (advance) pm_pc = pc + 1;
      return emitted;
   endfunction

   function automatic void restart_machine();
      foreach (pm_regs[i]) pm_regs[i] = 0;
      pm_acc = 0;
      pm_pc = 32'(pm_start);
      pm_dsp = 0;
      pm_rsp = 0;
      pm_status = hab_pkg::ST_RUN;
      pm_err = hab_pkg::ERR_NONE;
   endfunction

   // expected response of one accepted transaction
   function automatic machine_view_type predict_view(logic [1:0] op, logic [12:0] addr,
                                                     logic [7:0] data);
      machine_view_type v;
      logic [7:0] ch;
      bit emitted;
      emitted = 0;
      ch = 0;
      if (op == hab_pkg::REQ_WRITE) pm_mem[addr] = data;
      else if (op == hab_pkg::REQ_EXEC) begin
         if (pm_status == hab_pkg::ST_RUN) emitted = run_instruction(ch);
      end else if (op == hab_pkg::REQ_RESTART) restart_machine();
      v.char_valid = emitted;
      v.out_char = ch;
      v.machine_status = pm_status;
      v.error_code = pm_err;
      v.accumulator_value = pm_acc;
      v.counter_value = pm_pc;
      return v;
   endfunction

   // response check
   always @(posedge clock) begin
      machine_view_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.char_valid, rsp_bus.out_char, rsp_bus.machine_status,
                 rsp_bus.error_code, rsp_bus.accumulator_value, rsp_bus.counter_value};
         results_seen++;
         if (got.char_valid) chars_seen++;
         if (expected_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_views.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at response %0d: expected %p got %p",
                           results_seen, want, got);
            end
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one transaction on the request channel; entered and left at a falling edge
   task automatic send_item(logic [1:0] op, logic [12:0] addr, logic [7:0] data);
      if ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < idle_pct) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.load_address <= addr;
      req_bus.program_byte <= data;
      do @(posedge clock); while (!req_bus.ready);
      expected_views.push_back(predict_view(op, addr, data));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_views.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [12:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         hab_pkg::CSR_START: pm_start = val;
         hab_pkg::CSR_DBASE: pm_dbase = val;
         default:            pm_rbase = val;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_text(logic [12:0] at, string s);
      for (int i = 0; i < s.len(); i++)
         send_item(hab_pkg::REQ_WRITE, at + 13'(i), s[i]);
   endtask

   task automatic exec_steps(int n);
      repeat (n) send_item(hab_pkg::REQ_EXEC, 13'($urandom), 8'($urandom));
   endtask

   // most opcode classes, bad request code, odd offset digits
   task automatic test_directed();
      load_text(13'd256, "7e.s2+-AOXSr R_[0000B]0000jJ~<>PD!@ZfF9zC0000H");
      send_item(hab_pkg::REQ_RESTART, 13'd0, 8'd0);
      exec_steps(20);
      send_item(REQ_BAD, 13'h1fff, 8'hff);
      load_text(13'd300, "1s@_[");
      send_item(hab_pkg::REQ_WRITE, 13'd305, 8'h90);
      send_item(hab_pkg::REQ_WRITE, 13'd306, 8'hff);
      write_csr(hab_pkg::CSR_START, 13'd300);
      send_item(hab_pkg::REQ_RESTART, 13'd0, 8'd0);
      exec_steps(6);
   endtask

   // start at the last byte, stacks at both ends of memory
   task automatic test_config_extremes();
      write_csr(hab_pkg::CSR_START, 13'h1fff);
      write_csr(hab_pkg::CSR_DBASE, 13'h1fff);
      write_csr(hab_pkg::CSR_RBASE, 13'd0);
      send_item(hab_pkg::REQ_WRITE, 13'h1fff, "7");
      send_item(hab_pkg::REQ_RESTART, 13'd0, 8'd0);
      exec_steps(2);
      write_csr(hab_pkg::CSR_START, 13'd0);
      load_text(13'd0, "5ssSSrRRq");
      send_item(hab_pkg::REQ_RESTART, 13'd0, 8'd0);
      exec_steps(10);
   endtask

   // random programs, restarted and stepped, mixed with stray transactions
   task automatic test_random_programs(int idle, int stall, int target);
      string pool;
      string prog;
      int stop_at, len, start, pick;
      pool = "0123456789abcdefijklmnIJKLMNPsrSRD+-AOX!@.~_<> B\t\nHp";
      idle_pct = idle;
      stall_pct = stall;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         len = $urandom_range(6, 24);
         case ($urandom_range(3))
            0: start = 0;
            1: start = DEPTH - 1 - len;
            default: start = $urandom_range(DEPTH - 1 - len);
         endcase
         write_csr(hab_pkg::CSR_START, 13'(start));
         write_csr(hab_pkg::CSR_DBASE, ($urandom_range(3) == 0) ? 13'h1fff : 13'($urandom));
         write_csr(hab_pkg::CSR_RBASE, ($urandom_range(3) == 0) ? 13'd0 : 13'($urandom));
         prog = "";
         while (prog.len() < len) begin
            case ($urandom_range(9))
               0: prog = {prog, ($urandom_range(1) ? "[" : "Z"), "0000"};
               1: prog = {prog, ($urandom_range(1) ? "]" : "C"), "0000"};
               default: begin
                  pick = $urandom_range(pool.len() - 1);
                  prog = {prog, pool.substr(pick, pick)};
               end
            endcase
         end
         prog = prog.substr(0, len - 1);
         load_text(13'(start), prog);
         if ($urandom_range(4) == 0)
            send_item(2'($urandom_range(3)), 13'($urandom), 8'($urandom));
         send_item(hab_pkg::REQ_RESTART, 13'($urandom), 8'($urandom));
         exec_steps($urandom_range(8, 30));
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = hab_pkg::REQ_WRITE;
      req_bus.load_address = '0;
      req_bus.program_byte = '0;
      rsp_bus.ready = 1'b0;
      foreach (pm_mem[i]) pm_mem[i] = 8'h00;
      restart_machine();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_config_extremes();
      test_random_programs(0, 0, RAND_ITEMS / 4);
      test_random_programs(69, 0, RAND_ITEMS / 4);
      test_random_programs(0, 69, RAND_ITEMS / 4);
      test_random_programs(15, 15, RAND_ITEMS / 4);

      req_bus.valid <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("%0d transactions sent, %0d responses checked, %0d characters emitted",
               items_sent, results_seen, chars_seen);
      $display("covered opcodes, bracket scans, stack extremes and four idle patterns");
      if (mismatches == 0 && expected_views.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
